### rtl/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared types and constants for the fixed-length frame deframer.
// ----------------------------------------------------------------------------
package ffd_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int STORE_LEN   = FRAME_BYTES - 1;  // last frame byte is the live input
    localparam int PAYLOAD_AT  = 2;
    localparam int PAYLOAD_LEN = 5;
    localparam int CHECK_AT    = PAYLOAD_AT + PAYLOAD_LEN;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W       = $clog2(STORE_LEN);

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam logic [7:0] TAIL_BYTE  = 8'h0D;

    typedef logic [7:0]       t_byte;
    typedef logic [CNT_W-1:0] t_count;
    typedef logic [IDX_W-1:0] t_idx;
    typedef t_byte [STORE_LEN-1:0]   t_store;
    typedef t_byte [PAYLOAD_LEN-1:0] t_payload;

    // next buffer state from the scan logic
    typedef struct packed {
        t_store store;
        t_count count;
    } t_scan_next;

    // frame result from the scan logic
    typedef struct packed {
        logic     emit;
        t_payload payload;
        logic     sum_ok;
    } t_result;

endpackage

### rtl/ffd_scan.sv
// ----------------------------------------------------------------------------
// ffd_scan
// Per-byte buffer update: append, header tracking, tail check, rescan on a
// bad tail, and checksum of a completed frame.
// ----------------------------------------------------------------------------
module ffd_scan (
    input  ffd_pkg::t_store     i_store,
    input  ffd_pkg::t_count     i_count,
    input  ffd_pkg::t_byte      i_byte,
    output ffd_pkg::t_scan_next o_next,
    output ffd_pkg::t_result    o_res
);
    import ffd_pkg::*;

    t_byte             frame [FRAME_BYTES];
    logic [FRAME_BYTES-2:1] hdr_hit;   // bit i: header pair at frame position i
    t_idx              sel;
    logic              found;
    t_byte             sum;

    // full frame view: stored bytes plus the incoming one
    always_comb begin
        for (int k = 0; k < STORE_LEN; k++) begin
            frame[k] = i_store[k];
        end
        frame[FRAME_BYTES-1] = i_byte;
    end

    // rescan candidates after dropping the first byte
    always_comb begin
        hdr_hit = '0;
        for (int i = 1; i < FRAME_BYTES - 1; i++) begin
            hdr_hit[i] = (frame[i] == HDR_FIRST) && (frame[i+1] == HDR_SECOND);
        end
        sel   = '0;
        found = 1'b0;
        for (int i = FRAME_BYTES - 2; i >= 1; i--) begin
            if (hdr_hit[i]) begin
                sel   = IDX_W'(i);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            sum = t_byte'(sum + frame[PAYLOAD_AT+i]);
        end
    end

    always_comb begin
        o_next.store = i_store;
        o_next.count = '0;
        o_res.emit   = 1'b0;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            o_res.payload[i] = frame[PAYLOAD_AT+i];
        end
        o_res.sum_ok = (sum == frame[CHECK_AT]);

        if (i_count == '0) begin
            // empty: only a first header byte is worth keeping
            o_next.store[0] = HDR_FIRST;
            o_next.count    = (i_byte == HDR_FIRST) ? t_count'(1) : t_count'(0);
        end else if (i_count == t_count'(1)) begin
            // holding a lone first header byte
            o_next.store[0] = HDR_FIRST;
            o_next.store[1] = i_byte;
            if (i_byte == HDR_SECOND) begin
                o_next.count = t_count'(2);
            end else if (i_byte == HDR_FIRST) begin
                o_next.count = t_count'(1);
            end else begin
                o_next.count = '0;
            end
        end else if (i_count < t_count'(STORE_LEN)) begin
            // header in place, still filling
            o_next.store[i_count[IDX_W-1:0]] = i_byte;
            o_next.count = t_count'(i_count + t_count'(1));
        end else if (i_byte == TAIL_BYTE) begin
            o_res.emit   = 1'b1;
            o_next.count = '0;
        end else if (found) begin
            // bad tail: realign on the next header in the frame
            for (int s = 1; s < FRAME_BYTES - 1; s++) begin
                if (sel == IDX_W'(s)) begin
                    for (int k = 0; k < FRAME_BYTES - s; k++) begin
                        o_next.store[k] = frame[k+s];
                    end
                end
            end
            o_next.count = t_count'(t_count'(FRAME_BYTES) - t_count'(sel));
        end else begin
            o_next.store[0] = HDR_FIRST;
            o_next.count    = (i_byte == HDR_FIRST) ? t_count'(1) : t_count'(0);
        end
    end

endmodule

### rtl/fixed_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// fixed_frame_deframer_core
// Byte-stream deframer for fixed 9-byte frames (AA 55, five payload bytes,
// 8-bit sum checksum, 0D tail).
// ----------------------------------------------------------------------------
// Takes one received byte per transfer and delivers one result transfer per
// completed frame: the five payload bytes and a checksum-match flag. Frames
// with a bad checksum are still delivered, so check o_sum_ok. Bytes ahead of
// a header are discarded; a wrong tail realigns on the next header inside
// the frame. The block sustains one byte per clock while the result register
// is free: a taken byte lands in the input register, then the scan logic
// updates the frame buffer and loads the result register, so o_out_valid
// rises once the scan of the tail byte has fired. The buffer update loop
// (buffer and fill count through the scan logic) sets this rate. A held
// result stalls the input only when a new byte is ready to be processed.
// ----------------------------------------------------------------------------
module fixed_frame_deframer_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // byte input
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ffd_pkg::t_byte i_rx_byte,
    // frame output
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ffd_pkg::t_byte o_payload_0,
    output ffd_pkg::t_byte o_payload_1,
    output ffd_pkg::t_byte o_payload_2,
    output ffd_pkg::t_byte o_payload_3,
    output ffd_pkg::t_byte o_payload_4,
    output logic          o_sum_ok
);
    import ffd_pkg::*;

    // input register
    logic       r_in_valid;
    t_byte      r_in_byte;

    // frame buffer: r_store[0] is the oldest byte. After each update it is
    // empty, holds a lone AA, or starts with the AA 55 header.
    t_store     r_store;
    t_count     r_count;

    // result register
    logic       r_out_valid;
    t_payload   r_payload;
    logic       r_sum_ok;

    t_scan_next s_next;
    t_result    s_res;
    logic       s_out_free;
    logic       s_fire;
    logic       s_in_take;

    ffd_scan u_scan (
        .i_store (r_store),
        .i_count (r_count),
        .i_byte  (r_in_byte),
        .o_next  (s_next),
        .o_res   (s_res)
    );

    // the buffered byte is processed once the result register can take
    // whatever it produces
    assign s_out_free = !r_out_valid || !i_out_stall;
    assign s_fire     = r_in_valid && s_out_free;
    assign o_in_stall = r_in_valid && !s_out_free;
    assign s_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_in_take) begin
            r_in_valid <= 1'b1;
        end else if (s_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (s_fire) begin
            r_count <= s_next.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_store <= s_next.store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= s_res.emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && s_res.emit) begin
            r_payload <= s_res.payload;
            r_sum_ok  <= s_res.sum_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_payload_0 = r_payload[0];
    assign o_payload_1 = r_payload[1];
    assign o_payload_2 = r_payload[2];
    assign o_payload_3 = r_payload[3];
    assign o_payload_4 = r_payload[4];
    assign o_sum_ok    = r_sum_ok;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(STORE_LEN))
        else $error("frame buffer fill count out of range");

    a_header_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= t_count'(2)) |-> (r_store[0] == HDR_FIRST && r_store[1] == HDR_SECOND))
        else $error("buffer does not start with a header");

    a_lone_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == t_count'(1)) |-> (r_store[0] == HDR_FIRST))
        else $error("single buffered byte is not a header start");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && s_res.emit) |=> o_out_valid)
        else $error("completed frame not presented");

    a_stall_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled without a pending byte and held result");
`endif

endmodule
